[hdl/raw_string_identifier_lexer_unit_defines.svh]
// Assertion macros shared by the lexer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RAW_STRING_IDENTIFIER_LEXER_UNIT_DEFINES_SVH
`define RAW_STRING_IDENTIFIER_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsil check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsil check failed");

`endif

[hdl/rsil_pkg.sv]
// Types, character codes and helper functions for the raw string / identifier lexer.
// Depends on nothing; used by the step logic, the top level and the bench.
package rsil_pkg;

	// Scan modes of the token recognizer
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_R_SEEN  = 3'd2,
		MODE_HASHES  = 3'd3,
		MODE_CONTENT = 3'd4,
		MODE_CLOSING = 3'd5
	} mode_t;

	// Token kinds
	localparam logic [1:0] KIND_IDENT = 2'd0;
	localparam logic [1:0] KIND_RAW   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Character codes
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Recognizer state carried from item to item
	typedef struct packed {
		mode_t       mode;
		logic [15:0] byte_position;
		logic [7:0]  opening_hashes;
		logic [7:0]  closing_hashes;
		logic [15:0] content_start;
		logic [15:0] content_end;
	} lex_state_t;

	localparam lex_state_t STATE_IDLE = '{
		mode:           MODE_IDLE,
		byte_position:  16'd0,
		opening_hashes: 8'd0,
		closing_hashes: 8'd0,
		content_start:  16'd0,
		content_end:    16'd0
	};

	// One recognized token
	typedef struct packed {
		logic [1:0]  token_kind;
		logic [15:0] token_length;
		logic [15:0] content_offset;
		logic [15:0] content_length;
	} token_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
	endfunction

endpackage

[hdl/rsil_if.sv]
// Valid/ready channel interfaces for source bytes and recognized tokens.
// Depends on nothing beyond the language; used by the lexer top level.
interface rsil_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface rsil_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [15:0] token_length;
	logic [15:0] content_offset;
	logic [15:0] content_length;

	modport source (output valid, output token_kind, output token_length,
		output content_offset, output content_length, input ready);
	modport sink (input valid, input token_kind, input token_length,
		input content_offset, input content_length, output ready);
endinterface

[hdl/rsil_step.sv]
// Next-state and result logic of the lexer for one source byte.
// Depends on rsil_pkg; instantiated by raw_string_identifier_lexer_unit.
module rsil_step
	import rsil_pkg::*;
#(
	parameter logic [7:0]  HASH_MAX  = 8'd255,
	parameter logic [15:0] LEN_LIMIT = 16'hFFFF
) (
	input  lex_state_t st,
	input  logic [7:0] c,
	output lex_state_t nxt,
	output logic       res_valid,
	output token_t     res
);

	logic        can_bump;
	logic [15:0] bp_inc;
	logic [15:0] fail_len;
	logic [8:0]  close_inc;
	logic        fail_hit;

	// Length limit and saturated error length
	assign can_bump  = st.byte_position < LEN_LIMIT;
	assign bp_inc    = st.byte_position + 16'd1;
	assign fail_len  = (st.byte_position == LEN_LIMIT) ? LEN_LIMIT : bp_inc;
	assign close_inc = {1'b0, st.closing_hashes} + 9'd1;

	// Advance the recognizer by one byte
	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		fail_hit  = 1'b0;
		case (st.mode)
			MODE_IDENT: begin
				if (is_ident(c)) begin
					if (can_bump) nxt.byte_position = bp_inc;
					else fail_hit = 1'b1;
				end else begin
					res_valid        = 1'b1;
					res.token_kind   = KIND_IDENT;
					res.token_length = st.byte_position;
				end
			end
			MODE_R_SEEN: begin
				if (c == CH_HASH || c == CH_QUOTE || is_ident(c)) begin
					if (!can_bump) begin
						fail_hit = 1'b1;
					end else begin
						nxt.byte_position = bp_inc;
						if (c == CH_HASH) begin
							nxt.opening_hashes = 8'd1;
							nxt.mode           = MODE_HASHES;
						end else if (c == CH_QUOTE) begin
							nxt.opening_hashes = 8'd0;
							nxt.content_start  = bp_inc;
							nxt.mode           = MODE_CONTENT;
						end else begin
							nxt.mode = MODE_IDENT;
						end
					end
				end else begin
					// lone r is a one-byte identifier
					res_valid        = 1'b1;
					res.token_kind   = KIND_IDENT;
					res.token_length = st.byte_position;
				end
			end
			MODE_HASHES: begin
				if (c == CH_HASH) begin
					if (st.opening_hashes >= HASH_MAX || !can_bump) begin
						fail_hit = 1'b1;
					end else begin
						nxt.opening_hashes = st.opening_hashes + 8'd1;
						nxt.byte_position  = bp_inc;
					end
				end else if (c == CH_QUOTE) begin
					if (can_bump) begin
						nxt.byte_position = bp_inc;
						nxt.content_start = bp_inc;
						nxt.mode          = MODE_CONTENT;
					end else begin
						fail_hit = 1'b1;
					end
				end else begin
					fail_hit = 1'b1;
				end
			end
			MODE_CONTENT: begin
				if (c == CH_NUL || !can_bump) begin
					fail_hit = 1'b1;
				end else if (c == CH_QUOTE && st.opening_hashes == 8'd0) begin
					res_valid          = 1'b1;
					res.token_kind     = KIND_RAW;
					res.token_length   = bp_inc;
					res.content_offset = st.content_start;
					res.content_length = st.byte_position - st.content_start;
				end else if (c == CH_QUOTE) begin
					nxt.content_end    = st.byte_position;
					nxt.byte_position  = bp_inc;
					nxt.closing_hashes = 8'd0;
					nxt.mode           = MODE_CLOSING;
				end else begin
					nxt.byte_position = bp_inc;
				end
			end
			MODE_CLOSING: begin
				if (c == CH_NUL || !can_bump) begin
					fail_hit = 1'b1;
				end else if (c == CH_HASH) begin
					if (close_inc >= {1'b0, st.opening_hashes}) begin
						res_valid          = 1'b1;
						res.token_kind     = KIND_RAW;
						res.token_length   = bp_inc;
						res.content_offset = st.content_start;
						res.content_length = st.content_end - st.content_start;
					end else begin
						nxt.byte_position  = bp_inc;
						nxt.closing_hashes = close_inc[7:0];
					end
				end else if (c == CH_QUOTE) begin
					// restart the closing sequence at this quote
					nxt.content_end    = st.byte_position;
					nxt.byte_position  = bp_inc;
					nxt.closing_hashes = 8'd0;
				end else begin
					nxt.byte_position  = bp_inc;
					nxt.closing_hashes = 8'd0;
					nxt.mode           = MODE_CONTENT;
				end
			end
			default: begin
				nxt = STATE_IDLE;
				if (c == CH_R) begin
					nxt.byte_position = 16'd1;
					nxt.mode          = MODE_R_SEEN;
				end else if (is_alpha(c) || c == CH_UNDER) begin
					nxt.byte_position = 16'd1;
					nxt.mode          = MODE_IDENT;
				end else begin
					fail_hit = 1'b1;
				end
			end
		endcase

		// Drop back to idle after any token or error
		if (fail_hit) begin
			res_valid          = 1'b1;
			res.token_kind     = KIND_ERROR;
			res.token_length   = fail_len;
			res.content_offset = 16'd0;
			res.content_length = 16'd0;
		end
		if (res_valid) nxt = STATE_IDLE;
	end

endmodule

[hdl/raw_string_identifier_lexer_unit.sv]
// Raw string and identifier lexer: one source byte per item on src, one token per item
// on tok. An item accepted on src is registered, then stepped through the recognizer
// when the output side has room; a token it completes is registered and shown on
// tok. A new byte is taken in every cycle while tok is not stalled, since each byte
// only updates the scan mode register and the position and hash counters. The output
// register lets the next byte enter while a finished token waits to be taken.
// Depends on rsil_pkg, rsil_if, rsil_step and the assertion macro header.
`include "raw_string_identifier_lexer_unit_defines.svh"

module raw_string_identifier_lexer_unit
	import rsil_pkg::*;
#(
	parameter int unsigned MAX_HASHES    = 255,
	parameter int unsigned MAX_TOKEN_LEN = 65535
) (
	input logic         clk,
	input logic         arst_n,
	rsil_byte_if.sink   src,
	rsil_token_if.source tok
);

	localparam logic [15:0] LEN_LIMIT =
		(MAX_TOKEN_LEN > 32'd65535) ? 16'hFFFF : MAX_TOKEN_LEN[15:0];
	localparam logic [7:0]  HASH_MAX  = MAX_HASHES[7:0];

	logic       valid_s1;
	logic [7:0] byte_s1;
	lex_state_t state_q;
	lex_state_t state_nxt;
	logic       res_valid;
	token_t     res;
	logic       out_valid_q;
	token_t     out_q;
	logic       adv;
	logic       src_take;
	logic [16:0] raw_span;

	// Step the registered byte when the output side has room
	assign adv      = valid_s1 && (!out_valid_q || tok.ready);
	assign src.ready = !valid_s1 || adv;
	assign src_take = src.valid && src.ready;

	rsil_step #(
		.HASH_MAX  (HASH_MAX),
		.LEN_LIMIT (LEN_LIMIT)
	) u_step (
		.st        (state_q),
		.c         (byte_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Control: input stage valid, recognizer state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= STATE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (src_take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) state_q <= state_nxt;
			if (adv && res_valid) out_valid_q <= 1'b1;
			else if (tok.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload: hold the input byte and the finished token
	always_ff @(posedge clk) begin
		if (src_take) byte_s1 <= src.source_byte;
		if (adv && res_valid) out_q <= res;
	end

	assign tok.valid          = out_valid_q;
	assign tok.token_kind     = out_q.token_kind;
	assign tok.token_length   = out_q.token_length;
	assign tok.content_offset = out_q.content_offset;
	assign tok.content_length = out_q.content_length;

	assign raw_span = {1'b0, out_q.content_offset} + {1'b0, out_q.content_length};

	// Checks on recognizer state and produced tokens
	`RSIL_ASSERT_IMPL(a_pos_limit, clk, arst_n, 1'b1, state_q.byte_position <= LEN_LIMIT)
	`RSIL_ASSERT_IMPL(a_idle_clear, clk, arst_n, state_q.mode == MODE_IDLE,
		state_q.byte_position == 16'd0 && state_q.opening_hashes == 8'd0)
	`RSIL_ASSERT_NEXT(a_token_idles, clk, arst_n, adv && res_valid, state_q.mode == MODE_IDLE)
	`RSIL_ASSERT_IMPL(a_err_no_content, clk, arst_n,
		out_valid_q && out_q.token_kind == KIND_ERROR,
		out_q.content_offset == 16'd0 && out_q.content_length == 16'd0)
	`RSIL_ASSERT_IMPL(a_raw_inside, clk, arst_n,
		out_valid_q && out_q.token_kind == KIND_RAW,
		raw_span < {1'b0, out_q.token_length})

endmodule

[bench/raw_string_identifier_lexer_unit_test.sv]
// Self-checking bench for the raw string / identifier lexer: drives source bytes, predicts
// tokens with its own scanner model and checks every token field in order of arrival.
// Depends on rsil_pkg, the rsil_if channel interfaces and raw_string_identifier_lexer_unit.
module raw_string_identifier_lexer_unit_test;
	import rsil_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CAP      = 20_000;
	localparam int TAIL_CYCLES    = 8;
	localparam int unsigned HASH_CAP = 255;
	localparam int unsigned LEN_CAP  = 65535;

	logic clk;
	logic arst_n;

	rsil_byte_if  src();
	rsil_token_if tok();

	raw_string_identifier_lexer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src(src),
		.tok(tok)
	);

	int   src_idle_pct = 0;
	int   sink_stall_pct = 0;
	logic sink_held;
	event hold_start;
	int   sent_count = 0;
	int   fail_count = 0;

	token_t expected_tokens[$];

	// Scanner state of the predictor
	mode_t       lx_mode;
	int unsigned lx_pos;
	int unsigned lx_open;
	int unsigned lx_close;
	int unsigned lx_body_start;
	int unsigned lx_body_end;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

	// Character classes
	function automatic bit is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
	endfunction

	// Predictor: scanner model
	function automatic void lex_clear();
		lx_mode = MODE_IDLE;
		lx_pos = 0;
		lx_open = 0;
		lx_close = 0;
		lx_body_start = 0;
		lx_body_end = 0;
	endfunction

	// Count one more byte into the token; refuse past the length cap
	function automatic bit lex_grow();
		if (lx_pos + 1 > LEN_CAP)
			return 1'b0;
		lx_pos++;
		return 1'b1;
	endfunction

	function automatic bit lex_emit(input logic [1:0] kind, input int unsigned len,
			input int unsigned off, input int unsigned clen, output token_t tk);
		tk.token_kind = kind;
		tk.token_length = 16'(len);
		tk.content_offset = 16'(off);
		tk.content_length = 16'(clen);
		lex_clear();
		return 1'b1;
	endfunction

	function automatic bit lex_fail(output token_t tk);
		int unsigned n;
		n = lx_pos + 1;
		if (n > LEN_CAP)
			n = LEN_CAP;
		return lex_emit(KIND_ERROR, n, 0, 0, tk);
	endfunction

	// Advance the scanner by one byte; return 1 when a token completes
	function automatic bit lex_byte(input logic [7:0] c, output token_t tk);
		tk = '0;
		case (lx_mode)
			MODE_IDENT: begin
				if (word_char(c)) begin
					if (!lex_grow())
						return lex_fail(tk);
					return 1'b0;
				end
				return lex_emit(KIND_IDENT, lx_pos, 0, 0, tk);
			end
			MODE_R_SEEN: begin
				if (c == CH_HASH) begin
					if (!lex_grow())
						return lex_fail(tk);
					lx_open = 1;
					lx_mode = MODE_HASHES;
				end else if (c == CH_QUOTE) begin
					if (!lex_grow())
						return lex_fail(tk);
					lx_open = 0;
					lx_body_start = lx_pos;
					lx_mode = MODE_CONTENT;
				end else if (word_char(c)) begin
					if (!lex_grow())
						return lex_fail(tk);
					lx_mode = MODE_IDENT;
				end else begin
					// lone r: an identifier of its own, the byte after it is dropped
					return lex_emit(KIND_IDENT, lx_pos, 0, 0, tk);
				end
				return 1'b0;
			end
			MODE_HASHES: begin
				if (c == CH_HASH) begin
					if (lx_open >= HASH_CAP || !lex_grow())
						return lex_fail(tk);
					lx_open++;
				end else if (c == CH_QUOTE) begin
					if (!lex_grow())
						return lex_fail(tk);
					lx_body_start = lx_pos;
					lx_mode = MODE_CONTENT;
				end else begin
					return lex_fail(tk);
				end
				return 1'b0;
			end
			MODE_CONTENT: begin
				if (c == CH_NUL)
					return lex_fail(tk);
				if (c == CH_QUOTE) begin
					if (lx_open == 0) begin
						if (!lex_grow())
							return lex_fail(tk);
						return lex_emit(KIND_RAW, lx_pos, lx_body_start,
							lx_pos - 1 - lx_body_start, tk);
					end
					lx_body_end = lx_pos;
					if (!lex_grow())
						return lex_fail(tk);
					lx_close = 0;
					lx_mode = MODE_CLOSING;
					return 1'b0;
				end
				if (!lex_grow())
					return lex_fail(tk);
				return 1'b0;
			end
			MODE_CLOSING: begin
				if (c == CH_NUL)
					return lex_fail(tk);
				if (c == CH_HASH) begin
					if (!lex_grow())
						return lex_fail(tk);
					lx_close++;
					if (lx_close >= lx_open)
						return lex_emit(KIND_RAW, lx_pos, lx_body_start,
							lx_body_end - lx_body_start, tk);
					return 1'b0;
				end
				if (c == CH_QUOTE) begin
					// restart the closing sequence at this quote
					lx_body_end = lx_pos;
					if (!lex_grow())
						return lex_fail(tk);
					lx_close = 0;
					return 1'b0;
				end
				if (!lex_grow())
					return lex_fail(tk);
				lx_close = 0;
				lx_mode = MODE_CONTENT;
				return 1'b0;
			end
			default: begin
				lex_clear();
				if (c == CH_R) begin
					lx_pos = 1;
					lx_mode = MODE_R_SEEN;
					return 1'b0;
				end
				if (is_letter(c) || c == CH_UNDER) begin
					lx_pos = 1;
					lx_mode = MODE_IDENT;
					return 1'b0;
				end
				return lex_fail(tk);
			end
		endcase
	endfunction

	// Predict on every accepted byte
	always @(posedge clk) begin
		token_t tk;
		if (src.valid && src.ready) begin
			if (lex_byte(src.source_byte, tk))
				expected_tokens.push_back(tk);
		end
	end

	// Check every accepted token against the oldest prediction
	always @(posedge clk) begin
		token_t want;
		if (tok.valid && tok.ready) begin
			if (expected_tokens.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected token: kind %0d len %0d off %0d clen %0d",
						tok.token_kind, tok.token_length, tok.content_offset,
						tok.content_length);
			end else begin
				want = expected_tokens.pop_front();
				if (tok.token_kind !== want.token_kind ||
						tok.token_length !== want.token_length ||
						tok.content_offset !== want.content_offset ||
						tok.content_length !== want.content_length) begin
					fail_count++;
					if (fail_count <= 10)
						$display("token mismatch: expected kind %0d len %0d off %0d clen %0d,",
							want.token_kind, want.token_length, want.content_offset,
							want.content_length,
							" got kind %0d len %0d off %0d clen %0d",
							tok.token_kind, tok.token_length,
							tok.content_offset, tok.content_length);
				end
			end
		end
	end

	// Token sink: random stalls, plus a long hold-off on request
	always @(posedge clk)
		tok.ready <= !sink_held && ($urandom_range(99) >= sink_stall_pct);

	initial begin
		sink_held = 1'b0;
		forever begin
			@(hold_start);
			sink_held <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_held <= 1'b0;
		end
	end

	// Offer one byte, with a random idle gap first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			src.valid <= 1'b0;
			@(posedge clk);
		end
		src.valid <= 1'b1;
		src.source_byte <= b;
		do @(posedge clk); while (!src.ready);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Drop valid and wait until every predicted token has come out, up to the drain cap
	task automatic settle();
		int waited;
		src.valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (expected_tokens.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Random byte pickers
	function automatic logic [7:0] pick_word_char();
		case ($urandom_range(3))
			0: return 8'($urandom_range(8'h61, 8'h7A));
			1: return 8'($urandom_range(8'h41, 8'h5A));
			2: return 8'($urandom_range(8'h30, 8'h39));
			default: return CH_UNDER;
		endcase
	endfunction

	function automatic logic [7:0] pick_start_char();
		logic [7:0] c;
		do c = pick_word_char(); while (!(is_letter(c) || c == CH_UNDER) || c == CH_R);
		return c;
	endfunction

	function automatic logic [7:0] pick_delim(input bit allow_marks);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (word_char(c) || (!allow_marks && (c == CH_HASH || c == CH_QUOTE)));
		return c;
	endfunction

	function automatic logic [7:0] pick_body_char();
		case ($urandom_range(7))
			0: return CH_QUOTE;
			1: return CH_HASH;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_raw_body(input int hashes, input int count);
		logic [7:0] c;
		repeat (count) begin
			c = pick_body_char();
			if (hashes == 0 && c == CH_QUOTE)
				c = 8'h71;
			send_byte(c);
		end
	endtask

	// One random token: mostly well formed, some noise and broken ones
	task automatic send_random_token();
		int n;
		case ($urandom_range(9))
			0, 1, 2: begin
				send_byte(pick_start_char());
				repeat ($urandom_range(0, 8)) send_byte(pick_word_char());
				send_byte(pick_delim(1'b1));
			end
			3, 4, 5, 6: begin
				n = ($urandom_range(4) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
				send_byte(CH_R);
				repeat (n) send_byte(CH_HASH);
				send_byte(CH_QUOTE);
				send_raw_body(n, $urandom_range(0, 12));
				// partial closing sequence that falls back to content
				if (n > 1 && $urandom_range(1)) begin
					send_byte(CH_QUOTE);
					repeat ($urandom_range(0, n - 1)) send_byte(CH_HASH);
					send_byte(8'h78);
				end
				send_byte(CH_QUOTE);
				repeat (n) send_byte(CH_HASH);
			end
			7: begin
				send_byte(CH_R);
				if ($urandom_range(1)) begin
					repeat ($urandom_range(1, 5)) send_byte(pick_word_char());
					send_byte(pick_delim(1'b1));
				end else begin
					send_byte(pick_delim(1'b0));
				end
			end
			8: begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				n = $urandom_range(0, 3);
				send_byte(CH_R);
				repeat (n) send_byte(CH_HASH);
				case ($urandom_range(2))
					0: send_byte(pick_delim(1'b0));
					1: begin
						send_byte(CH_QUOTE);
						send_raw_body(n, $urandom_range(0, 4));
						send_byte(CH_NUL);
					end
					default: begin
						send_byte(CH_QUOTE);
						send_raw_body(n, $urandom_range(0, 4));
						if (n > 0) begin
							send_byte(CH_QUOTE);
							repeat ($urandom_range(0, n - 1)) send_byte(CH_HASH);
						end
						send_byte(CH_NUL);
					end
				endcase
			end
		endcase
	endtask

	// Identifiers: shortest, mixed classes, odd terminators
	task automatic test_identifiers();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_text("_ ");
		send_text("a");
		send_byte(8'hFF);
		send_text("Zq9_x");
		send_byte(CH_NUL);
		settle();
	endtask

	// Bytes that cannot start a token
	task automatic test_bad_start_bytes();
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_byte(CH_HASH);
		send_byte(CH_QUOTE);
		send_text("7");
		send_byte(8'h80);
		settle();
	endtask

	// Raw strings, lone r, identifier through r and the error cases
	task automatic test_raw_strings();
		send_text("r\"\"");
		send_text("r#\"a\"b\"#");
		send_text("r##\"\"#y\"##");
		send_text("r-");
		send_text("rx ");
		send_text("r#x");
		send_text("r\"");
		send_byte(CH_NUL);
		send_text("r#\"\"");
		send_byte(CH_NUL);
		settle();
	endtask

	// Largest hash count is taken; one hash more is an error
	task automatic test_hash_limit();
		send_byte(CH_R);
		repeat (HASH_CAP + 1) send_byte(CH_HASH);
		settle();
	endtask

	// Hold off the sink while bytes keep coming so the input stalls
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		-> hold_start;
		repeat (80) send_byte(pick_delim(1'b1));
		settle();
	endtask

	task automatic test_random_tokens(input int idle_pct, input int stall_pct,
			input int count);
		int target;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		target = sent_count + count;
		while (sent_count < target)
			send_random_token();
		settle();
	endtask

	// Reset, run the tests, report
	initial begin
		src.valid = 1'b0;
		src.source_byte = 8'h00;
		tok.ready = 1'b0;
		lex_clear();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identifiers();
		test_bad_start_bytes();
		test_raw_strings();
		test_hash_limit();
		test_output_backpressure();
		test_random_tokens(0, 0, 90);
		test_random_tokens(84, 0, 90);
		test_random_tokens(0, 84, 90);
		test_random_tokens(12, 12, 90);

		if (expected_tokens.size() != 0) begin
			fail_count += expected_tokens.size();
			$display("%0d predicted tokens never arrived", expected_tokens.size());
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/rsil_pkg.sv
hdl/rsil_if.sv
hdl/rsil_step.sv
hdl/raw_string_identifier_lexer_unit.sv
bench/raw_string_identifier_lexer_unit_test.sv
